### rtl/sdsum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsum_pkg
// Shared widths, constants and types of the sph density summation core.
// ----------------------------------------------------------------------------
package sdsum_pkg;

  // fixed point format
  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 24;
  localparam int INV_W      = 24;
  localparam int SCALE_W    = 32;
  localparam int SUM_W      = 40;
  localparam int IDX_W      = 16;
  localparam int OUT_IDX_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // derived widths
  localparam int PROD_W    = DIST_W + INV_W;       // distance times 1/h
  localparam int QF_W      = PROD_W - FRAC_W;      // q before range check
  localparam int Q_W       = FRAC_W + 1;           // q in [0, one]
  localparam int W_W       = FRAC_W + 1;           // kernel weight in [0, one]
  localparam int POS_W     = FRAC_W + 4;           // one plus six times q3
  localparam int SIX_W     = FRAC_W + 3;           // six times a fraction
  localparam int CONTRIB_W = W_W + SCALE_W - FRAC_W;
  localparam int SUMX_W    = SUM_W + 1;

  localparam logic [Q_W-1:0]   ONE     = Q_W'(1) << FRAC_W;
  localparam logic [Q_W-1:0]   HALF    = Q_W'(1) << (FRAC_W - 1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // register reset values
  localparam logic [INV_W-1:0]   INV_SMOOTH_RST   = INV_W'(65536);
  localparam logic [SCALE_W-1:0] KERNEL_SCALE_RST = SCALE_W'(166886);

  // queue depths
  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_SMOOTH   = 1'b0,
    CFG_KERNEL_SCALE = 1'b1
  } cfg_reg_e;

  // what one item asks of the back end
  typedef struct packed {
    logic add;      // carries a neighbour
    logic emit;     // closes the particle
    logic last_pt;  // closes the range
  } tag_t;

  typedef struct packed {
    logic [DIST_W-1:0] nb_dist;
    tag_t              tag;
  } item_t;

  // kernel pipeline to accumulator
  typedef struct packed {
    logic [CONTRIB_W-1:0] contrib;
    tag_t                 tag;
  } kres_t;

endpackage

### rtl/sdsum_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsum_front
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module sdsum_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sdsum_pkg::DIST_W-1:0]  distance_i,
  input  logic                          neighbor_valid_i,
  input  logic                          last_neighbor_i,
  input  logic                          last_particle_i,
  output sdsum_pkg::item_t              item_o,
  output logic                          item_valid_o,
  input  logic                          item_pop_i
);

  sdsum_pkg::item_t                   mem_q [sdsum_pkg::IQ_DEPTH];
  logic [sdsum_pkg::IQ_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sdsum_pkg::IQ_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sdsum_pkg::IQ_CNT_W-1:0]     cnt_q, cnt_d;
  sdsum_pkg::item_t                   new_item;
  logic                               keep;
  logic                               wr_en;
  logic                               rd_en;

  // classify: an item that neither adds nor emits is dropped
  always_comb begin
    new_item.nb_dist     = distance_i;
    new_item.tag.add     = neighbor_valid_i;
    new_item.tag.emit    = last_neighbor_i;
    new_item.tag.last_pt = last_particle_i;
    keep                 = neighbor_valid_i | last_neighbor_i;
  end

  assign full         = (cnt_q == sdsum_pkg::IQ_CNT_W'(sdsum_pkg::IQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push & ~full & keep;
  assign rd_en        = item_pop_i & item_valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sdsum_pkg::IQ_CNT_W'(sdsum_pkg::IQ_DEPTH))
    else $error("front queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> item_valid_o)
    else $error("front queue popped while empty");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && !wr_en) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("front queue count did not drop on pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != sdsum_pkg::IQ_CNT_W'(sdsum_pkg::IQ_DEPTH)) |->
      (sdsum_pkg::IQ_PTR_W'(wr_ptr_q - rd_ptr_q) ==
       sdsum_pkg::IQ_PTR_W'(cnt_q)))
    else $error("front queue pointers disagree with count");

endmodule

### rtl/sdsum_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsum_kernel
// Five stage cubic spline evaluator: q, square, cube, weight, scale.
// Holds the two configuration registers.
// ----------------------------------------------------------------------------
module sdsum_kernel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sdsum_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sdsum_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  sdsum_pkg::item_t                  item_i,
  input  logic                              item_valid_i,
  output logic                              item_pop_o,
  input  logic                              adv_i,
  output sdsum_pkg::kres_t                  res_o,
  output logic                              res_valid_o
);

  localparam int F = sdsum_pkg::FRAC_W;

  logic [sdsum_pkg::INV_W-1:0]   inv_q;
  logic [sdsum_pkg::SCALE_W-1:0] scale_q;
  sdsum_pkg::cfg_reg_e           cfg_sel;

  logic [4:0]                    v_q;
  sdsum_pkg::tag_t               tag_q [5];

  logic [sdsum_pkg::PROD_W-1:0]  prod1;
  logic [sdsum_pkg::QF_W-1:0]    qf1;
  logic [sdsum_pkg::Q_W-1:0]     q1_q;
  logic                          zero1_q;

  logic                          half2;
  logic [sdsum_pkg::Q_W-1:0]     tdiff2;
  logic [F-1:0]                  x2in;
  logic [2*F-1:0]                sq2;
  logic [F-1:0]                  x2_q, sqr2_q;
  logic                          half2_q, zero2_q;

  logic [2*F-1:0]                cu3;
  logic [F-1:0]                  sqr3_q, cub3_q;
  logic                          half3_q, zero3_q;

  logic [sdsum_pkg::SIX_W-1:0]   six_sq4, six_cu4;
  logic [sdsum_pkg::POS_W-1:0]   pos4, neg4;
  logic [sdsum_pkg::W_W-1:0]     w4_d, w4_q;

  logic [sdsum_pkg::W_W+sdsum_pkg::SCALE_W-1:0] wprod5;
  logic [sdsum_pkg::CONTRIB_W-1:0]              contrib5_q;

  // configuration registers
  assign cfg_sel = sdsum_pkg::cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= sdsum_pkg::INV_SMOOTH_RST;
      scale_q <= sdsum_pkg::KERNEL_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        sdsum_pkg::CFG_INV_SMOOTH:   inv_q   <= cfg_wdata_i[sdsum_pkg::INV_W-1:0];
        sdsum_pkg::CFG_KERNEL_SCALE: scale_q <= cfg_wdata_i[sdsum_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together
  assign item_pop_o  = adv_i & item_valid_i;
  assign res_valid_o = v_q[4];
  assign res_o.contrib = contrib5_q;
  assign res_o.tag     = tag_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], item_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= item_i.tag;
      tag_q[1] <= tag_q[0];
      tag_q[2] <= tag_q[1];
      tag_q[3] <= tag_q[2];
      tag_q[4] <= tag_q[3];
    end
  end

  // stage 1: q = distance * 1/h, flag q beyond one
  assign prod1 = sdsum_pkg::PROD_W'(item_i.nb_dist) * sdsum_pkg::PROD_W'(inv_q);
  assign qf1   = prod1[sdsum_pkg::PROD_W-1:F];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      q1_q    <= qf1[sdsum_pkg::Q_W-1:0];
      zero1_q <= (qf1 > sdsum_pkg::QF_W'(sdsum_pkg::ONE));
    end
  end

  // stage 2: pick q or 1-q and square it
  assign half2  = (q1_q <= sdsum_pkg::HALF);
  assign tdiff2 = sdsum_pkg::ONE - q1_q;
  assign x2in   = half2 ? q1_q[F-1:0] : tdiff2[F-1:0];
  assign sq2    = (2*F)'(x2in) * (2*F)'(x2in);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x2_q    <= x2in;
      sqr2_q  <= sq2[2*F-1:F];
      half2_q <= half2;
      zero2_q <= zero1_q;
    end
  end

  // stage 3: cube
  assign cu3 = (2*F)'(sqr2_q) * (2*F)'(x2_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sqr3_q  <= sqr2_q;
      cub3_q  <= cu3[2*F-1:F];
      half3_q <= half2_q;
      zero3_q <= zero2_q;
    end
  end

  // stage 4: spline weight
  assign six_sq4 = {2'b00, sqr3_q, 1'b0} + {1'b0, sqr3_q, 2'b00};
  assign six_cu4 = {2'b00, cub3_q, 1'b0} + {1'b0, cub3_q, 2'b00};
  assign pos4    = sdsum_pkg::POS_W'(sdsum_pkg::ONE) + sdsum_pkg::POS_W'(six_cu4);
  assign neg4    = sdsum_pkg::POS_W'(six_sq4);

  always_comb begin
    w4_d = '0;
    if (zero3_q) begin
      w4_d = '0;
    end else if (half3_q) begin
      if (pos4 > neg4) begin
        w4_d = sdsum_pkg::W_W'(pos4 - neg4);
      end
    end else begin
      w4_d = {cub3_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w4_q <= w4_d;
    end
  end

  // stage 5: scale by mass and normalisation
  assign wprod5 = (sdsum_pkg::W_W + sdsum_pkg::SCALE_W)'(w4_q) *
                  (sdsum_pkg::W_W + sdsum_pkg::SCALE_W)'(scale_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      contrib5_q <= wprod5[sdsum_pkg::W_W+sdsum_pkg::SCALE_W-1:F];
    end
  end

  // checks
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv_i && v_q[4]) |=> (v_q[4] && $stable(contrib5_q)))
    else $error("kernel output changed while stalled");

  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (w4_d <= sdsum_pkg::W_W'(sdsum_pkg::ONE)))
    else $error("kernel weight above one");

  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |=> v_q[0])
    else $error("popped item did not enter the pipe");

endmodule

### rtl/sdsum_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdsum_accum
// Saturating per-particle sum, particle counter and result queue.
// ----------------------------------------------------------------------------
module sdsum_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sdsum_pkg::kres_t                  res_i,
  input  logic                              res_valid_i,
  output logic                              adv_o,
  output logic                              empty,
  input  logic                              pop,
  output logic [sdsum_pkg::SUM_W-1:0]       particle_density_o,
  output logic [sdsum_pkg::OUT_IDX_W-1:0]   particle_index_o
);

  logic [sdsum_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic [sdsum_pkg::IDX_W-1:0]       pidx_q, pidx_d;
  logic [sdsum_pkg::SUMX_W-1:0]      sum_ext;
  logic [sdsum_pkg::SUM_W-1:0]       sum_new;

  logic [sdsum_pkg::SUM_W-1:0]       dens_mem_q [sdsum_pkg::OQ_DEPTH];
  logic [sdsum_pkg::OUT_IDX_W-1:0]   idx_mem_q  [sdsum_pkg::OQ_DEPTH];
  logic [sdsum_pkg::OQ_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [sdsum_pkg::OQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              ofull;
  logic                              take;
  logic                              emit_en;
  logic                              rd_en;

  assign ofull   = (cnt_q == sdsum_pkg::OQ_CNT_W'(sdsum_pkg::OQ_DEPTH));
  assign adv_o   = ~(res_valid_i & res_i.tag.emit & ofull);
  assign take    = res_valid_i & adv_o;
  assign emit_en = take & res_i.tag.emit;
  assign empty   = (cnt_q == '0);
  assign rd_en   = pop & ~empty;

  // saturating add
  assign sum_ext = sdsum_pkg::SUMX_W'(sum_q) + sdsum_pkg::SUMX_W'(res_i.contrib);
  always_comb begin
    sum_new = sum_q;
    if (res_i.tag.add) begin
      sum_new = sum_ext[sdsum_pkg::SUM_W] ? sdsum_pkg::SUM_MAX
                                          : sum_ext[sdsum_pkg::SUM_W-1:0];
    end
  end

  // sum and particle counter
  always_comb begin
    sum_d  = sum_q;
    pidx_d = pidx_q;
    if (take) begin
      sum_d = sum_new;
      if (res_i.tag.emit) begin
        sum_d  = '0;
        pidx_d = res_i.tag.last_pt ? '0 : pidx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pidx_q <= '0;
    end else begin
      sum_q  <= sum_d;
      pidx_q <= pidx_d;
    end
  end

  // result queue control
  always_comb begin
    cnt_d = cnt_q;
    if (emit_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!emit_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (emit_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      dens_mem_q[wr_ptr_q] <= sum_new;
      idx_mem_q[wr_ptr_q]  <= pidx_q[sdsum_pkg::OUT_IDX_W-1:0];
    end
  end

  assign particle_density_o = dens_mem_q[rd_ptr_q];
  assign particle_index_o   = idx_mem_q[rd_ptr_q];

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sdsum_pkg::OQ_CNT_W'(sdsum_pkg::OQ_DEPTH))
    else $error("result queue count out of range");

  a_clear_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |=> (sum_q == '0))
    else $error("sum not cleared after emit");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |-> (!ofull || rd_en))
    else $error("result written into a full queue");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |=> !empty)
    else $error("emitted item not visible");

endmodule

### rtl/sph_density_summation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_density_summation_core
// Cubic spline sph density summation: per-neighbour kernel weight,
// saturating per-particle sum, one result per particle.
//
//   channel   handshake          payload
//   input     push / full        distance_i, neighbor_valid_i, last_neighbor_i,
//                                last_particle_i
//   result    empty / pop        particle_density_o, particle_index_o
//   config    cfg_we_i           cfg_idx_i, cfg_wdata_i (no wait)
//
// one item per cycle sustained while the result queue has room; the five stage
// kernel pipe moves one step a cycle unless halted, and feeds the accumulator.
// an item that closes a particle is held in the front queue, passes the five
// kernel stage registers, then is written to the result queue and visible.
// reset clears sum, particle counter and both queues at once; no sweep.
// a full result queue halts the kernel pipe once a closing item reaches its
// end; the 4 deep front queue then absorbs input until full rises.
// ----------------------------------------------------------------------------
module sph_density_summation_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sdsum_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sdsum_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                              push,
  output logic                              full,
  input  logic [sdsum_pkg::DIST_W-1:0]      distance_i,
  input  logic                              neighbor_valid_i,
  input  logic                              last_neighbor_i,
  input  logic                              last_particle_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [sdsum_pkg::SUM_W-1:0]       particle_density_o,
  output logic [sdsum_pkg::OUT_IDX_W-1:0]   particle_index_o
);

  sdsum_pkg::item_t  item;
  logic              item_valid;
  logic              item_pop;
  logic              adv;
  sdsum_pkg::kres_t  kres;
  logic              kres_valid;

  // front: accept and classify
  sdsum_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .distance_i       (distance_i),
    .neighbor_valid_i (neighbor_valid_i),
    .last_neighbor_i  (last_neighbor_i),
    .last_particle_i  (last_particle_i),
    .item_o           (item),
    .item_valid_o     (item_valid),
    .item_pop_i       (item_pop)
  );

  // kernel evaluation pipe
  sdsum_kernel u_kernel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .adv_i        (adv),
    .res_o        (kres),
    .res_valid_o  (kres_valid)
  );

  // accumulation and result queue
  sdsum_accum u_accum (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .res_i              (kres),
    .res_valid_i        (kres_valid),
    .adv_o              (adv),
    .empty              (empty),
    .pop                (pop),
    .particle_density_o (particle_density_o),
    .particle_index_o   (particle_index_o)
  );

endmodule
